@@ src/swfd_pkg.sv @@
// Shared constants and types of the sync word frame deframer.
// No dependencies; the parser, result register and top level refer to it by scoped names.
package swfd_pkg;

  // Header byte pair: first byte, then second byte
  localparam logic [7:0] HDR_FIRST  = 8'hFF;
  localparam logic [7:0] HDR_SECOND = 8'hFE;

  // Reset value of the maximum length register
  localparam logic [15:0] MAX_LENGTH_RESET = 16'd4096;

  // Fixed part of the length field: two command bytes plus two sum bytes
  localparam logic [15:0] LEN_OVERHEAD = 16'd4;

  // Result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_END     = 1'b1;

  // End of frame status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_BAD_SUM  = 2'd1;
  localparam logic [1:0] STATUS_TOO_LONG = 2'd2;

  typedef struct packed {
    logic        out_kind;
    logic [7:0]  payload_byte;
    logic [15:0] command;
    logic [1:0]  frame_status;
    logic [15:0] frame_length;
    logic        last_of_frame;
  } swfd_result_t;

endpackage

@@ src/swfd_if.sv @@
// Channel interfaces: byte stream in, result words out, register write.
// Depends on nothing; widths follow the frame format.
interface swfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface swfd_result_if;
  logic        valid;
  logic        ready;
  logic        out_kind;
  logic [7:0]  payload_byte;
  logic [15:0] command;
  logic [1:0]  frame_status;
  logic [15:0] frame_length;
  logic        last_of_frame;

  modport source (output valid, output out_kind, output payload_byte, output command,
                  output frame_status, output frame_length, output last_of_frame,
                  input ready);
  modport sink (input valid, input out_kind, input payload_byte, input command,
                input frame_status, input frame_length, input last_of_frame,
                output ready);
endinterface

interface swfd_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] max_length;

  modport source (output valid, output max_length, input ready);
  modport sink (input valid, input max_length, output ready);
endinterface

@@ src/swfd_in_stage.sv @@
// Input register of the deframer: holds one received word until the
// parser takes it. Depends on swfd_byte_if.
module swfd_in_stage (
  input  logic       clk,
  input  logic       rst,
  swfd_byte_if.sink  stream,
  input  logic       space,
  output logic       step,
  output logic [7:0] held_byte
);

  logic full;

  // Advance when a word is held and the result side has room
  assign step         = full && space;
  assign stream.ready = !full || step;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (stream.valid && stream.ready) begin
      full <= 1'b1;
    end else if (step) begin
      full <= 1'b0;
    end
  end

  // Capture the word
  always_ff @(posedge clk) begin
    if (stream.valid && stream.ready) begin
      held_byte <= stream.in_byte;
    end
  end

endmodule

@@ src/swfd_parse.sv @@
// Frame parser: header hunt, length, command, payload and sum phases.
// Depends on swfd_pkg for header bytes, codes and the result type.
module swfd_parse (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [7:0]           in_byte,
  input  logic [15:0]          max_length,
  output logic                 emit,
  output swfd_pkg::swfd_result_t result
);

  localparam logic [2:0] PH_HUNT    = 3'd0;
  localparam logic [2:0] PH_LENGTH  = 3'd1;
  localparam logic [2:0] PH_COMMAND = 3'd2;
  localparam logic [2:0] PH_PAYLOAD = 3'd3;
  localparam logic [2:0] PH_SUM     = 3'd4;

  logic [2:0]  phase,         phase_next;
  logic [7:0]  previous_byte, previous_byte_next;
  logic [15:0] field_count,   field_count_next;
  logic [15:0] length_value,  length_value_next;
  logic [15:0] payload_len,   payload_len_next;
  logic [15:0] command_value, command_value_next;
  logic [15:0] running_sum,   running_sum_next;
  logic [7:0]  sum_low_byte,  sum_low_byte_next;
  logic [15:0] count_inc;
  logic [15:0] got_sum;

  assign count_inc = field_count + 16'd1;
  assign got_sum   = {in_byte, sum_low_byte};

  // Work out the next state and the result of one word
  always_comb begin
    phase_next         = phase;
    previous_byte_next = previous_byte;
    field_count_next   = field_count;
    length_value_next  = length_value;
    payload_len_next   = payload_len;
    command_value_next = command_value;
    running_sum_next   = running_sum;
    sum_low_byte_next  = sum_low_byte;
    emit               = 1'b0;
    result             = '0;
    result.command     = command_value;
    result.frame_length = length_value;

    unique case (phase)
      PH_HUNT: begin
        if (previous_byte == swfd_pkg::HDR_FIRST && in_byte == swfd_pkg::HDR_SECOND) begin
          phase_next         = PH_LENGTH;
          field_count_next   = '0;
          length_value_next  = '0;
          command_value_next = '0;
          running_sum_next   = '0;
          sum_low_byte_next  = '0;
          previous_byte_next = '0;
        end else begin
          previous_byte_next = in_byte;
        end
      end

      PH_LENGTH: begin
        // Only the two low length bytes count
        if (field_count == 16'd0) begin
          length_value_next = {8'd0, in_byte};
        end else if (field_count == 16'd1) begin
          length_value_next = {in_byte, length_value[7:0]};
        end
        field_count_next = count_inc;
        if (field_count == 16'd3) begin
          payload_len_next = (length_value < swfd_pkg::LEN_OVERHEAD) ? 16'd0
                             : length_value - swfd_pkg::LEN_OVERHEAD;
          if (length_value > max_length) begin
            // Reject at once; no command read yet
            emit                 = 1'b1;
            result.out_kind      = swfd_pkg::KIND_END;
            result.command       = '0;
            result.frame_status  = swfd_pkg::STATUS_TOO_LONG;
            result.last_of_frame = 1'b1;
            phase_next           = PH_HUNT;
            previous_byte_next   = '0;
            field_count_next     = '0;
          end else begin
            phase_next       = PH_COMMAND;
            field_count_next = '0;
          end
        end
      end

      PH_COMMAND: begin
        if (field_count == 16'd0) begin
          command_value_next = {8'd0, in_byte};
          field_count_next   = 16'd1;
        end else begin
          command_value_next = {in_byte, command_value[7:0]};
          field_count_next   = '0;
          phase_next         = (payload_len == 16'd0) ? PH_SUM : PH_PAYLOAD;
        end
      end

      PH_PAYLOAD: begin
        running_sum_next = running_sum + {8'd0, in_byte};
        field_count_next = count_inc;
        if (count_inc >= payload_len) begin
          phase_next       = PH_SUM;
          field_count_next = '0;
        end
        emit                = 1'b1;
        result.out_kind     = swfd_pkg::KIND_PAYLOAD;
        result.payload_byte = in_byte;
      end

      PH_SUM: begin
        if (field_count == 16'd0) begin
          sum_low_byte_next = in_byte;
          field_count_next  = 16'd1;
        end else begin
          emit                 = 1'b1;
          result.out_kind      = swfd_pkg::KIND_END;
          result.frame_status  = (got_sum == running_sum) ? swfd_pkg::STATUS_OK
                                 : swfd_pkg::STATUS_BAD_SUM;
          result.last_of_frame = 1'b1;
          phase_next           = PH_HUNT;
          previous_byte_next   = '0;
          field_count_next     = '0;
        end
      end

      default: begin
        phase_next         = PH_HUNT;
        previous_byte_next = '0;
        field_count_next   = '0;
      end
    endcase
  end

  // Hold the parser state; advance one word per step
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      previous_byte <= '0;
      field_count   <= '0;
      length_value  <= '0;
      payload_len   <= '0;
      command_value <= '0;
      running_sum   <= '0;
      sum_low_byte  <= '0;
    end else if (step) begin
      phase         <= phase_next;
      previous_byte <= previous_byte_next;
      field_count   <= field_count_next;
      length_value  <= length_value_next;
      payload_len   <= payload_len_next;
      command_value <= command_value_next;
      running_sum   <= running_sum_next;
      sum_low_byte  <= sum_low_byte_next;
    end
  end

endmodule

@@ src/swfd_out_stage.sv @@
// Result register of the deframer: holds one result word for the sink.
// Depends on swfd_pkg for the result type and on swfd_result_if.
module swfd_out_stage (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  logic                   emit,
  input  swfd_pkg::swfd_result_t result_in,
  output logic                   space,
  swfd_result_if.source          result
);

  swfd_pkg::swfd_result_t held;

  // Room when empty or when the held word leaves this cycle
  assign space = !result.valid || result.ready;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (load) begin
      result.valid <= emit;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  // Capture a new result word
  always_ff @(posedge clk) begin
    if (load && emit) begin
      held <= result_in;
    end
  end

  assign result.out_kind      = held.out_kind;
  assign result.payload_byte  = held.payload_byte;
  assign result.command       = held.command;
  assign result.frame_status  = held.frame_status;
  assign result.frame_length  = held.frame_length;
  assign result.last_of_frame = held.last_of_frame;

endmodule

@@ src/sync_word_frame_deframer.sv @@
// Top level of the sync word frame deframer: input register, parser, result register.
// Depends on swfd_pkg, swfd_if, swfd_in_stage, swfd_parse and swfd_out_stage.
//
//   channel  direction  payload                               handshake
//   stream   in         in_byte                               valid/ready
//   result   out        kind, byte, command, status, length   valid/ready
//   cfg      in         max_length                            valid/ready (always ready)
//
// One word per cycle while the result sink does not stall: each word crosses the input
// register, the parser logic and the result register; its result is loaded into the
// result register when the parser steps on the word and is offered to the sink from then on.
// Synchronous reset returns to header hunt and sets max_length to 4096.
// A stalled result sink holds the result register; one more word can still be
// taken into the input register before stream ready drops.
module sync_word_frame_deframer (
  input  logic          clk,
  input  logic          rst,
  swfd_byte_if.sink     stream,
  swfd_result_if.source result,
  swfd_cfg_if.sink      cfg
);

  logic                   step;
  logic [7:0]             held_byte;
  logic                   space;
  logic                   emit;
  logic [15:0]            max_length;
  swfd_pkg::swfd_result_t parsed;

  // Maximum length register
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= swfd_pkg::MAX_LENGTH_RESET;
    end else if (cfg.valid) begin
      max_length <= cfg.max_length;
    end
  end

  swfd_in_stage u_in_stage (
    .clk       (clk),
    .rst       (rst),
    .stream    (stream),
    .space     (space),
    .step      (step),
    .held_byte (held_byte)
  );

  swfd_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .in_byte    (held_byte),
    .max_length (max_length),
    .emit       (emit),
    .result     (parsed)
  );

  swfd_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .load      (step),
    .emit      (emit),
    .result_in (parsed),
    .space     (space),
    .result    (result)
  );

endmodule
